// ----- rtl/ledc_pkg.sv -----
// ----------------------------------------------------------------------------
// ledc_pkg
// Shared types and constants of the line-edge robot drive controller.
// ----------------------------------------------------------------------------
package ledc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_COMBAT_MODE       = 3'd0,
    CFG_ESCAPE_TICKS      = 3'd1,
    CFG_SWEEP_TICKS       = 3'd2,
    CFG_ROTATE_TICKS      = 3'd3,
    CFG_SWEEPS_PER_ROTATE = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Speed constants.
  localparam logic [7:0] FullSpeed   = 8'd255;
  localparam logic [7:0] SoftTurn    = 8'd128;
  localparam logic [7:0] EscapeTurn  = 8'd127;
  localparam logic [7:0] HardTurn    = 8'd0;
  localparam logic [7:0] SeekBase    = 8'd64;
  localparam logic [7:0] SeekTurn    = 8'd32;
  localparam logic [7:0] SweepRestart = 8'd5;

  // Reset values of the configuration registers.
  localparam logic [7:0] EscapeTicksRst  = 8'd8;
  localparam logic [7:0] SweepTicksRst   = 8'd10;
  localparam logic [7:0] RotateTicksRst  = 8'd24;
  localparam logic [3:0] SweepsPerRotRst = 4'd4;

  // Sensor history bit positions.
  localparam int unsigned SenseL = 0;
  localparam int unsigned SenseB = 1;
  localparam int unsigned SenseR = 2;

  // Command codes.
  localparam logic CmdSensor = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef struct packed {
    logic cmd;
    logic left_hit;
    logic right_hit;
    logic back_hit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] duty_one;
    logic [7:0] duty_two;
    logic       reverse_flag;
    logic       escaping_flag;
  } out_item_t;

  typedef struct packed {
    logic       combat_mode;
    logic [7:0] escape_ticks;
    logic [7:0] sweep_ticks;
    logic [7:0] rotate_ticks;
    logic [3:0] sweeps_per_rotate;
  } cfg_t;

endpackage

// ----- rtl/ledc_in_if.sv -----
// ----------------------------------------------------------------------------
// ledc_in_if
// Valid/ready channel carrying sensor and tick beats into the controller.
// ----------------------------------------------------------------------------
interface ledc_in_if
  import ledc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ledc_out_if.sv -----
// ----------------------------------------------------------------------------
// ledc_out_if
// Valid/ready channel carrying motor command beats out of the controller.
// ----------------------------------------------------------------------------
interface ledc_out_if
  import ledc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ledc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ledc_cfg_regs
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module ledc_cfg_regs
  import ledc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index and update one field.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COMBAT_MODE:       cfg_d.combat_mode       = cfg_wdata_i[0];
        CFG_ESCAPE_TICKS:      cfg_d.escape_ticks      = cfg_wdata_i;
        CFG_SWEEP_TICKS:       cfg_d.sweep_ticks       = cfg_wdata_i;
        CFG_ROTATE_TICKS:      cfg_d.rotate_ticks      = cfg_wdata_i;
        CFG_SWEEPS_PER_ROTATE: cfg_d.sweeps_per_rotate = cfg_wdata_i[3:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.combat_mode       <= 1'b0;
      cfg_q.escape_ticks      <= EscapeTicksRst;
      cfg_q.sweep_ticks       <= SweepTicksRst;
      cfg_q.rotate_ticks      <= RotateTicksRst;
      cfg_q.sweeps_per_rotate <= SweepsPerRotRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ledc_core.sv -----
// ----------------------------------------------------------------------------
// ledc_core
// Drive state registers and the single-pass update for one beat.
// ----------------------------------------------------------------------------
module ledc_core
  import ledc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  typedef struct packed {
    logic [7:0] base_speed;
    logic [7:0] inner_speed;
    logic       turning_right;
    logic       turning_left;
    logic       reverse;
    logic       escaping;
    logic       rotating;
    logic       sweep_dir;
    logic       timer_running;
    logic [7:0] escape_count;
    logic [7:0] rotate_count;
    logic [7:0] sweep_count;
    logic [3:0] sweep_rounds;
    logic [2:0] hist_old;
    logic [2:0] hist_new;
    logic [7:0] duty_one;
    logic [7:0] duty_two;
  } drive_state_t;

  drive_state_t state_q, state_d;
  logic         l, r, b;
  logic [2:0]   hit_pattern;

  function automatic drive_state_t go_right(drive_state_t s);
    drive_state_t t;
    t = s;
    t.turning_right = 1'b1;
    t.duty_one      = s.base_speed;
    t.duty_two      = s.inner_speed;
    return t;
  endfunction

  function automatic drive_state_t go_left(drive_state_t s);
    drive_state_t t;
    t = s;
    t.turning_left = 1'b1;
    t.duty_two     = s.base_speed;
    t.duty_one     = s.inner_speed;
    return t;
  endfunction

  function automatic drive_state_t go_straight(drive_state_t s);
    drive_state_t t;
    t = s;
    t.turning_right = 1'b0;
    t.turning_left  = 1'b0;
    t.duty_one      = s.base_speed;
    t.duty_two      = s.base_speed;
    return t;
  endfunction

  assign l = item_i.left_hit;
  assign r = item_i.right_hit;
  assign b = item_i.back_hit;

  always_comb begin
    hit_pattern         = '0;
    hit_pattern[SenseL] = l;
    hit_pattern[SenseB] = b;
    hit_pattern[SenseR] = r;
  end

  // Next drive state for the beat at hand.
  always_comb begin
    state_d = state_q;
    if (cfg_i.combat_mode) begin
      if (item_i.cmd == CmdTick) begin
        // Tick: advance whichever counter is active while the timers run.
        if (state_d.timer_running) begin
          if (state_d.escaping) begin
            state_d.escape_count = state_d.escape_count + 8'd1;
            if (state_d.escape_count == cfg_i.escape_ticks) begin
              state_d.escape_count = '0;
              state_d.reverse      = 1'b0;
              state_d.escaping     = 1'b0;
            end
          end else if (state_d.rotating) begin
            state_d.rotate_count = state_d.rotate_count + 8'd1;
            if (state_d.rotate_count == cfg_i.rotate_ticks) begin
              state_d.rotate_count = '0;
              state_d.rotating     = 1'b0;
              state_d              = go_straight(state_d);
              state_d.sweep_count  = SweepRestart;
            end
          end else begin
            state_d.sweep_count = state_d.sweep_count + 8'd1;
            if (state_d.sweep_count == cfg_i.sweep_ticks) begin
              state_d.sweep_dir    = !state_d.sweep_dir;
              state_d.sweep_count  = '0;
              state_d.sweep_rounds = state_d.sweep_rounds + 4'd1;
              if (state_d.sweep_rounds == cfg_i.sweeps_per_rotate) begin
                state_d.sweep_rounds = '0;
                state_d.rotating     = 1'b1;
              end
            end
          end
        end
      end else begin
        // Sensor change: pick an escape on a hit, restart timers on a clear.
        state_d.escaping = 1'b1;
        if (l || r || b) begin
          state_d.hist_old      = state_d.hist_new;
          state_d.hist_new      = hit_pattern;
          state_d.timer_running = 1'b0;
          state_d.escape_count  = '0;
          state_d.sweep_rounds  = '0;
          state_d.rotate_count  = '0;
          state_d.sweep_count   = '0;
          state_d.rotating      = 1'b0;
          state_d               = go_straight(state_d);
          state_d.base_speed    = FullSpeed;
          if (l && r) begin
            state_d.reverse = 1'b1;
            state_d         = go_straight(state_d);
          end else if (l || r) begin
            state_d.reverse     = !b;
            state_d.inner_speed = EscapeTurn;
            if (l) begin
              state_d = go_right(state_d);
            end else begin
              state_d = go_left(state_d);
            end
          end else begin
            state_d.reverse = 1'b0;
            state_d         = go_straight(state_d);
          end
        end else begin
          // Leaving a double front hit straightens the car.
          if (state_d.hist_old == ((3'b001 << SenseL) | (3'b001 << SenseR)) &&
              (state_d.hist_new[SenseL] || state_d.hist_new[SenseR])) begin
            state_d = go_straight(state_d);
          end
          state_d.hist_old      = state_d.hist_new;
          state_d.hist_new      = '0;
          state_d.timer_running = 1'b1;
          state_d.escape_count  = '0;
        end
      end
      // Seek sweep whenever no escape or rotate is in progress.
      if (!state_d.escaping && !state_d.rotating) begin
        state_d.base_speed  = SeekBase;
        state_d.inner_speed = SeekTurn;
        if (state_d.sweep_dir) begin
          state_d = go_right(state_d);
        end else begin
          state_d = go_left(state_d);
        end
      end
    end else if (item_i.cmd == CmdSensor) begin
      // Line tracking: soft turn on one sensor, hard turn when it is lost.
      if (l && r) begin
        state_d = go_straight(state_d);
      end else if (state_d.turning_right && !r && !l) begin
        state_d.inner_speed = HardTurn;
        state_d             = go_right(state_d);
      end else if (state_d.turning_left && !r && !l) begin
        state_d.inner_speed = HardTurn;
        state_d             = go_left(state_d);
      end else if (r) begin
        if (!state_d.turning_right) begin
          state_d.inner_speed = SoftTurn;
        end
        state_d = go_right(state_d);
      end else if (l) begin
        if (!state_d.turning_left) begin
          state_d.inner_speed = SoftTurn;
        end
        state_d = go_left(state_d);
      end else begin
        state_d = go_straight(state_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.base_speed    <= FullSpeed;
      state_q.inner_speed   <= SoftTurn;
      state_q.turning_right <= 1'b0;
      state_q.turning_left  <= 1'b0;
      state_q.reverse       <= 1'b0;
      state_q.escaping      <= 1'b0;
      state_q.rotating      <= 1'b0;
      state_q.sweep_dir     <= 1'b0;
      state_q.timer_running <= 1'b1;
      state_q.escape_count  <= '0;
      state_q.rotate_count  <= '0;
      state_q.sweep_count   <= SweepRestart;
      state_q.sweep_rounds  <= '0;
      state_q.hist_old      <= '0;
      state_q.hist_new      <= '0;
      state_q.duty_one      <= FullSpeed;
      state_q.duty_two      <= FullSpeed;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  // The result of the beat is the updated drive command.
  assign result_o.duty_one      = state_d.duty_one;
  assign result_o.duty_two      = state_d.duty_two;
  assign result_o.reverse_flag  = state_d.reverse;
  assign result_o.escaping_flag = state_d.escaping;

endmodule

// ----- rtl/line_edge_robot_drive_controller.sv -----
// ----------------------------------------------------------------------------
// line_edge_robot_drive_controller
// Line tracking and edge-escape drive controller with seek sweeps.
// ----------------------------------------------------------------------------
// Every input beat (a sensor change or a tick) yields exactly one output beat
// with both motor duties and the reverse and escaping flags. The block takes
// one beat per clock cycle while the output is not stalled; a beat is held in
// the input register, then the drive state and the result register update
// together once the result register is free, and the result is offered on
// the output from the result register. The state update is one pass of flag
// and counter logic, which sets the one-cycle rate. Write the configuration
// registers only while no beat is in flight.
module line_edge_robot_drive_controller
  import ledc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ledc_in_if.sink             in_i,
  ledc_out_if.source          out_o
);

  cfg_t      cfg;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;

  ledc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held beat moves on once the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  ledc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule
